>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character decode for the Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int LENGTH_WIDTH = 16;
    localparam int CAP_W        = 16;
    localparam int OUT_LEN_W    = 16;
    localparam int ROOM_W       = ((LENGTH_WIDTH > CAP_W) ? LENGTH_WIDTH : CAP_W) + 1;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int PADDR_W      = 3;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_OUT_CAPACITY = 3'd0;

    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_DONE  = 2'd1,
        TAIL_ERROR = 2'd2
    } t_tail;

    typedef struct packed {
        logic [1:0]              n_data;
        t_tail                   tail;
        logic [2:0][7:0]         bytes;
        logic [LENGTH_WIDTH-1:0] length;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet s;
        s.ok  = 1'b1;
        s.val = 6'd0;
        case (ch) inside
            [8'h41:8'h5A]: s.val = 6'(ch - 8'h41);
            [8'h61:8'h7A]: s.val = 6'(ch - 8'h61 + 8'd26);
            [8'h30:8'h39]: s.val = 6'(ch - 8'h30 + 8'd52);
            8'h2B:         s.val = 6'd62;
            8'h2F:         s.val = 6'd63;
            default:       s.ok  = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic has_room(input logic [LENGTH_WIDTH-1:0] bw,
                                      input logic [CAP_W-1:0] cap,
                                      input logic [1:0] k);
        return (ROOM_W'(bw) + ROOM_W'(k)) <= ROOM_W'(cap);
    endfunction

endpackage

>>> hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts character beats, tracks message state and issues result commands.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [7:0]                i_char,
    input  logic                      i_eoi,
    output logic                      o_ready,
    input  logic [b64d_pkg::CAP_W-1:0] i_capacity,
    input  logic                      i_full,
    output logic                      o_push,
    output b64d_pkg::t_cmd            o_cmd
);
    import b64d_pkg::*;

    logic [17:0]             r_acc, n_acc;
    logic [1:0]              r_pend, n_pend;
    logic [LENGTH_WIDTH-1:0] r_bw, n_bw;
    logic                    r_fin, n_fin;

    logic    accept;
    t_sextet sx;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign sx      = sextet_of(i_char);

    always_comb begin
        n_acc  = r_acc;
        n_pend = r_pend;
        n_bw   = r_bw;
        n_fin  = r_fin;
        o_push = 1'b0;
        o_cmd  = '{n_data: 2'd0, tail: TAIL_NONE, bytes: '0, length: '0};
        if (accept) begin
            if (i_eoi) begin
                if (!r_fin) begin
                    o_push = 1'b1;
                    if (r_pend != 2'd0) begin
                        o_cmd.tail = TAIL_ERROR;
                    end else begin
                        o_cmd.tail   = TAIL_DONE;
                        o_cmd.length = r_bw;
                    end
                end
                n_acc  = '0;
                n_pend = 2'd0;
                n_bw   = '0;
                n_fin  = 1'b0;
            end else if (!r_fin) begin
                if (i_char == CHAR_PAD) begin
                    o_push = 1'b1;
                    n_fin  = 1'b1;
                    case (r_pend)
                        2'd1: o_cmd.tail = TAIL_ERROR;
                        2'd2: begin
                            if (has_room(r_bw, i_capacity, 2'd1)) begin
                                n_bw           = r_bw + LENGTH_WIDTH'(1);
                                o_cmd.n_data   = 2'd1;
                                o_cmd.bytes[0] = r_acc[11:4];
                                o_cmd.tail     = TAIL_DONE;
                                o_cmd.length   = n_bw;
                            end else begin
                                o_cmd.tail = TAIL_ERROR;
                            end
                        end
                        2'd3: begin
                            if (has_room(r_bw, i_capacity, 2'd2)) begin
                                n_bw           = r_bw + LENGTH_WIDTH'(2);
                                o_cmd.n_data   = 2'd2;
                                o_cmd.bytes[0] = r_acc[17:10];
                                o_cmd.bytes[1] = r_acc[9:2];
                                o_cmd.tail     = TAIL_DONE;
                                o_cmd.length   = n_bw;
                            end else begin
                                o_cmd.tail = TAIL_ERROR;
                            end
                        end
                        default: begin
                            o_cmd.tail   = TAIL_DONE;
                            o_cmd.length = r_bw;
                        end
                    endcase
                end else if (sx.ok) begin
                    if (r_pend != 2'd3) begin
                        n_acc  = {r_acc[11:0], sx.val};
                        n_pend = r_pend + 2'd1;
                    end else if (!has_room(r_bw, i_capacity, 2'd3)) begin
                        o_push     = 1'b1;
                        o_cmd.tail = TAIL_ERROR;
                        n_fin      = 1'b1;
                    end else begin
                        o_push       = 1'b1;
                        o_cmd.n_data = 2'd3;
                        o_cmd.bytes[0] = r_acc[17:10];
                        o_cmd.bytes[1] = {r_acc[9:2]};
                        o_cmd.bytes[2] = {r_acc[1:0], sx.val};
                        n_bw         = r_bw + LENGTH_WIDTH'(3);
                        n_acc        = '0;
                        n_pend       = 2'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= 2'd0;
            r_bw   <= '0;
            r_fin  <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
            r_bw   <= n_bw;
            r_fin  <= n_fin;
        end
    end

endmodule

>>> hw/rtl/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Short command queue between the front and back sections.
// ----------------------------------------------------------------------------
module b64d_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output b64d_pkg::t_cmd o_head
);
    import b64d_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_PTR_W:0]   r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Expands queued commands into result beats, one beat per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  b64d_pkg::t_cmd                i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_byte,
    output logic [1:0]                    o_status,
    output logic [b64d_pkg::OUT_LEN_W-1:0] o_length,
    output logic                          o_last
);
    import b64d_pkg::*;

    logic                 r_valid;
    logic [1:0]           r_idx;
    logic [7:0]           r_byte;
    logic [1:0]           r_status;
    logic [OUT_LEN_W-1:0] r_length;
    logic                 r_last;

    logic       issue, is_data, is_last, has_tail;
    logic [1:0] last_idx;

    assign has_tail = (i_head.tail != TAIL_NONE);
    assign last_idx = i_head.n_data + {1'b0, has_tail} - 2'd1;
    assign issue    = !i_empty && (!r_valid || i_ready);
    assign is_data  = (r_idx < i_head.n_data);
    assign is_last  = (r_idx == last_idx);
    assign o_pop    = issue && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (issue) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_last <= is_last;
            if (is_data) begin
                r_byte   <= i_head.bytes[r_idx];
                r_status <= ST_DATA;
                r_length <= '0;
            end else if (i_head.tail == TAIL_DONE) begin
                r_byte   <= 8'd0;
                r_status <= ST_DONE;
                r_length <= OUT_LEN_W'(i_head.length);
            end else begin
                r_byte   <= 8'd0;
                r_status <= ST_ERROR;
                r_length <= '0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_status = r_status;
    assign o_length = r_length;
    assign o_last   = r_last;

endmodule

>>> hw/rtl/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming Base64 decoder with an APB capacity register.
// ----------------------------------------------------------------------------
// One character beat is taken every cycle while the four-entry command queue
// has room; each beat is classified as it is accepted. Results leave at one
// beat per cycle from the output register while tready is high, so a group
// of four characters yielding three bytes gives three data beats, and the
// input stalls only when tready stays low long enough to fill the queue. A
// beat with tlast set ends the message and rearms the decoder.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // [7:0] in_char
    input  logic                            i_s_axis_tlast,  // end_of_input
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [23:0]                     o_m_axis_tdata,  // [7:0] out_byte, [23:8] out_length
    output logic [1:0]                      o_m_axis_tuser,  // [1:0] status
    output logic                            o_m_axis_tlast,  // last
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [b64d_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [31:0]                     i_pwdata,
    output logic [31:0]                     o_prdata,
    output logic                            o_pready
);
    import b64d_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             cfg_wr, push, pop, full, empty;
    t_cmd             cmd, head;
    logic [7:0]       out_byte;
    logic [1:0]       out_status;
    logic [15:0]      out_length;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && (i_paddr == ADDR_OUT_CAPACITY);
    assign o_prdata = (i_paddr == ADDR_OUT_CAPACITY) ? 32'(r_capacity) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '1;
        end else if (cfg_wr) begin
            r_capacity <= i_pwdata[CAP_W-1:0];
        end
    end

    b64d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_char     (i_s_axis_tdata),
        .i_eoi      (i_s_axis_tlast),
        .o_ready    (o_s_axis_tready),
        .i_capacity (r_capacity),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    b64d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_byte   (out_byte),
        .o_status (out_status),
        .o_length (out_length),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {out_length, out_byte};
    assign o_m_axis_tuser = out_status;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_DATA)) |-> o_m_axis_tlast)
        else $error("done or error beat without tlast");

    a_end_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_DATA)) |-> (o_m_axis_tdata[7:0] == 8'd0))
        else $error("nonzero byte on done or error beat");

    a_data_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_DONE)) |-> (o_m_axis_tdata[23:8] == 16'd0))
        else $error("length set on a beat other than done");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("command pushed into full queue");

endmodule
